>>> sv/grid_local_peak_detector_defines.svh
// ---------------------------------------------------------------------------
// Grid local peak detector: assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef GRID_LOCAL_PEAK_DETECTOR_DEFINES_SVH
`define GRID_LOCAL_PEAK_DETECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GLP_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GLP_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

>>> sv/glp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid local peak detector package
// Shared constants, register indexes and the event type passed from the
// classify front end to the reporting back end.
// ---------------------------------------------------------------------------
package glp_pkg;

   // Geometry limits.
   localparam int GRID_MAX_COLS = 64;
   localparam logic [6:0] GRID_MIN_DIM = 7'd3;
   localparam logic [6:0] GRID_ROWS_LIMIT = 7'd64;
   localparam logic [6:0] GRID_COLS_RESET = 7'd7;
   localparam logic [6:0] GRID_ROWS_RESET = 7'd7;

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_COLS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_ROWS = 1'b1;

   // Result kinds.
   localparam logic KIND_PEAK = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Saturation point of the per-frame peak count.
   localparam logic [11:0] PEAK_COUNT_MAX = 12'hFFF;

   // Event queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic               peak;   // the tested cell is a peak
      logic               last;   // the item closed the frame
      logic signed [15:0] value;
      logic [5:0]         row;
      logic [5:0]         col;
   } glp_event_type;

endpackage

>>> sv/grid_local_peak_detector.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid local peak detector
// Four-neighbour local maximum search over a raster stream of Q12.4 samples.
// ---------------------------------------------------------------------------
// Samples enter on the req_ channel in raster order, one per accepted item.
// An interior cell is reported on the rsp_ channel as a peak (kind 0) when
// the sample directly below it arrives; the last sample of a frame yields a
// summary (kind 1) with the saturating peak count and the tallest peak, at
// least zero, after which the frame counters clear.
// Grid width and height are set through csr_ writes; the user makes them
// only while the block is idle, and the block itself does not enforce it.
// Throughput is one item per cycle while req_stall is low: the line stores
// are read once and written once per item. A result passes through the
// classify stage and the event queue, whose head the output register then
// takes.
// A four-entry event queue sits between the classify stage and the output
// register, so a stalled receiver only holds off new items once the queue
// and the classify stage together are full.
// Synchronous reset clears the raster position, the counters, the queue and
// the output valid, and restores a 7 by 7 grid; line store contents are not
// cleared and need no clearing pass.
// ---------------------------------------------------------------------------
`include "grid_local_peak_detector_defines.svh"

module grid_local_peak_detector #(
   parameter int MAX_COLS = glp_pkg::GRID_MAX_COLS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [15:0]              req_elevation,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_kind,
   output logic signed [15:0]              rsp_peak_value,
   output logic [5:0]                      rsp_peak_row,
   output logic [5:0]                      rsp_peak_col,
   output logic [11:0]                     rsp_peak_total,
   output logic [14:0]                     rsp_tallest,
   input  logic                            csr_wr_en,
   input  logic [glp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [glp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import glp_pkg::*;

   // Events travel from the classify stage through the queue to the back end.
   glp_event_type          q_event;
   glp_event_type          q_head;
   logic                   q_push;
   logic                   q_pop;
   logic                   q_valid;
   logic [QUEUE_CNT_W-1:0] q_count;

   glp_front #(
      .MAX_COLS(MAX_COLS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_elevation(req_elevation),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .q_count(q_count),
      .q_push(q_push),
      .q_event(q_event)
   );

   glp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data(q_event),
      .pop(q_pop),
      .head_data(q_head),
      .head_valid(q_valid),
      .count(q_count)
   );

   glp_back u_back (
      .clock(clock),
      .reset(reset),
      .head_data(q_head),
      .head_valid(q_valid),
      .pop(q_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_peak_value(rsp_peak_value),
      .rsp_peak_row(rsp_peak_row),
      .rsp_peak_col(rsp_peak_col),
      .rsp_peak_total(rsp_peak_total),
      .rsp_tallest(rsp_tallest)
   );

   // The admission check must keep the classify stage from pushing into a
   // full queue.
   `GLP_ASSERT_IMPLY(a_no_overflow, clock, reset, q_push && !q_pop, q_count < QUEUE_DEPTH, "event pushed into a full queue")

   // The queue never pops while empty.
   `GLP_ASSERT_IMPLY(a_no_underflow, clock, reset, q_pop, q_count != 0, "event popped from an empty queue")

   // A push without a pop grows the queue by exactly one entry.
   `GLP_ASSERT_NEXT(a_count_step, clock, reset, q_push && !q_pop, q_count == $past(q_count) + 1, "queue count did not advance")

   // Peaks are interior cells, so neither coordinate of a peak report is zero.
   `GLP_ASSERT_IMPLY(a_peak_interior, clock, reset, rsp_valid && rsp_kind == KIND_PEAK, rsp_peak_row != 0 && rsp_peak_col != 0, "peak reported on the border")

endmodule

>>> sv/glp_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid local peak detector: front end
// Accepts samples, tracks the raster position, keeps the two line stores and
// classifies the cell one row above, pushing peak and end-of-frame events.
// ---------------------------------------------------------------------------
module glp_front #(
   parameter int MAX_COLS = glp_pkg::GRID_MAX_COLS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [15:0]                req_elevation,
   input  logic                              csr_wr_en,
   input  logic [glp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [glp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [glp_pkg::QUEUE_CNT_W-1:0]   q_count,
   output logic                              q_push,
   output glp_pkg::glp_event_type            q_event
);
   import glp_pkg::*;

   localparam int COL_MAX = (MAX_COLS < 64) ? MAX_COLS : 64;
   localparam int ADDR_W = (COL_MAX > 1) ? $clog2(COL_MAX) : 1;
   localparam logic [6:0] COL_LIMIT = 7'(COL_MAX);

   // Configuration registers.
   logic [6:0] grid_cols_ff;
   logic [6:0] grid_rows_ff;

   // Raster position.
   logic [5:0] col_ff, col_in;
   logic [5:0] row_ff, row_in;
   logic       row_sel_ff, row_sel_in;

   // Line stores and their registered read data.
   logic signed [15:0] line_a_mem [COL_MAX];
   logic signed [15:0] line_b_mem [COL_MAX];
   logic signed [15:0] rd_a_ff, rd_b_ff;

   // Classify stage.
   logic               s2_valid_ff;
   logic signed [15:0] s2_x_ff;
   logic               s2_cand_ff;
   logic               s2_end_ff;
   logic [5:0]         s2_row_ff;
   logic [5:0]         s2_col_ff;
   logic               s2_sel_ff;

   // Sliding window over both stores: entry c-1 and entry c.
   logic signed [15:0] win1_a_ff, win1_b_ff, win2_a_ff, win2_b_ff;

   logic [6:0] cols, rows, col_p1;
   logic       accept, end_row, end_frame, cand;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic signed [15:0] prev_left, prev_mid, prev_right, upper;
   logic       is_peak;

   always_comb begin
      if (grid_cols_ff < GRID_MIN_DIM) begin
         cols = GRID_MIN_DIM;
      end else if (grid_cols_ff > COL_LIMIT) begin
         cols = COL_LIMIT;
      end else begin
         cols = grid_cols_ff;
      end
      if (grid_rows_ff < GRID_MIN_DIM) begin
         rows = GRID_MIN_DIM;
      end else if (grid_rows_ff > GRID_ROWS_LIMIT) begin
         rows = GRID_ROWS_LIMIT;
      end else begin
         rows = grid_rows_ff;
      end
   end

   // Room is needed for the item in the classify stage and for this one.
   assign req_stall = (q_count + QUEUE_CNT_W'(s2_valid_ff)) >= QUEUE_CNT_W'(QUEUE_DEPTH);
   assign accept = req_valid && !req_stall;

   assign col_p1 = {1'b0, col_ff} + 7'd1;
   assign end_row = {1'b0, col_ff} >= (cols - 7'd1);
   assign end_frame = end_row && ({1'b0, row_ff} >= (rows - 7'd1));
   assign cand = (row_ff >= 6'd2) && (col_ff != 6'd0) && (col_p1 < cols);

   // Each item fetches the entry the next item will need on its right; the
   // last item of a row fetches column zero for the row that follows.
   assign rd_addr = end_row ? '0 : col_p1[ADDR_W-1:0];
   assign wr_addr = col_ff[ADDR_W-1:0];

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      row_sel_in = row_sel_ff;
      if (accept) begin
         if (end_frame) begin
            col_in = '0;
            row_in = '0;
            row_sel_in = 1'b0;
         end else if (end_row) begin
            col_in = '0;
            row_in = row_ff + 6'd1;
            row_sel_in = !row_sel_ff;
         end else begin
            col_in = col_p1[5:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= GRID_COLS_RESET;
         grid_rows_ff <= GRID_ROWS_RESET;
         col_ff <= '0;
         row_ff <= '0;
         row_sel_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_GRID_COLS: grid_cols_ff <= csr_wdata;
               CSR_GRID_ROWS: grid_rows_ff <= csr_wdata;
               default: grid_cols_ff <= grid_cols_ff;
            endcase
         end
         col_ff <= col_in;
         row_ff <= row_in;
         row_sel_ff <= row_sel_in;
         s2_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (row_sel_ff) begin
            line_b_mem[wr_addr] <= req_elevation;
         end else begin
            line_a_mem[wr_addr] <= req_elevation;
         end
         rd_a_ff <= line_a_mem[rd_addr];
         rd_b_ff <= line_b_mem[rd_addr];
         s2_x_ff <= req_elevation;
         s2_cand_ff <= cand;
         s2_end_ff <= end_frame;
         s2_row_ff <= row_ff - 6'd1;
         s2_col_ff <= col_ff;
         s2_sel_ff <= row_sel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         win1_a_ff <= win2_a_ff;
         win1_b_ff <= win2_b_ff;
         win2_a_ff <= rd_a_ff;
         win2_b_ff <= rd_b_ff;
      end
   end

   // The store being filled holds the row above the tested cell.
   always_comb begin
      prev_left = s2_sel_ff ? win1_a_ff : win1_b_ff;
      prev_mid = s2_sel_ff ? win2_a_ff : win2_b_ff;
      prev_right = s2_sel_ff ? rd_a_ff : rd_b_ff;
      upper = s2_sel_ff ? win2_b_ff : win2_a_ff;
      is_peak = s2_cand_ff && (prev_mid > prev_left) && (prev_mid > prev_right)
                && (prev_mid > upper) && (prev_mid > s2_x_ff);
   end

   assign q_push = s2_valid_ff && (is_peak || s2_end_ff);
   always_comb begin
      q_event.peak = is_peak;
      q_event.last = s2_end_ff;
      q_event.value = prev_mid;
      q_event.row = s2_row_ff;
      q_event.col = s2_col_ff;
   end

endmodule

>>> sv/glp_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid local peak detector: event queue
// Small first-in first-out store that decouples the front end from the
// reporting back end.
// ---------------------------------------------------------------------------
module glp_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  glp_pkg::glp_event_type          push_data,
   input  logic                            pop,
   output glp_pkg::glp_event_type          head_data,
   output logic                            head_valid,
   output logic [glp_pkg::QUEUE_CNT_W-1:0] count
);
   import glp_pkg::*;

   glp_event_type slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;

   assign head_data = slot_ff[rd_ptr_ff];
   assign head_valid = count_ff != '0;
   assign count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QUEUE_CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QUEUE_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/glp_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid local peak detector: back end
// Counts peaks, tracks the tallest one and drives the registered result
// channel with peak reports and end-of-frame summaries.
// ---------------------------------------------------------------------------
module glp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  glp_pkg::glp_event_type head_data,
   input  logic                   head_valid,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_kind,
   output logic signed [15:0]     rsp_peak_value,
   output logic [5:0]             rsp_peak_row,
   output logic [5:0]             rsp_peak_col,
   output logic [11:0]            rsp_peak_total,
   output logic [14:0]            rsp_tallest
);
   import glp_pkg::*;

   logic               rsp_valid_ff;
   logic               kind_ff;
   logic signed [15:0] value_ff;
   logic [5:0]         row_ff;
   logic [5:0]         col_ff;
   logic [11:0]        total_ff;
   logic [14:0]        tallest_out_ff;

   logic [11:0]        peak_count_ff, peak_count_in;
   logic signed [15:0] tallest_ff, tallest_in;

   assign pop = head_valid && (!rsp_valid_ff || !rsp_stall);

   // A peak in the same event is counted before a summary reads the totals.
   always_comb begin
      peak_count_in = peak_count_ff;
      tallest_in = tallest_ff;
      if (head_data.peak) begin
         if (peak_count_ff != PEAK_COUNT_MAX) begin
            peak_count_in = peak_count_ff + 12'd1;
         end
         if (head_data.value > tallest_ff) begin
            tallest_in = head_data.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         peak_count_ff <= '0;
         tallest_ff <= '0;
      end else begin
         if (pop) begin
            rsp_valid_ff <= 1'b1;
            if (head_data.last) begin
               peak_count_ff <= '0;
               tallest_ff <= '0;
            end else begin
               peak_count_ff <= peak_count_in;
               tallest_ff <= tallest_in;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (head_data.last) begin
            kind_ff <= KIND_SUMMARY;
            value_ff <= '0;
            row_ff <= '0;
            col_ff <= '0;
            total_ff <= peak_count_in;
            tallest_out_ff <= tallest_in[14:0];
         end else begin
            kind_ff <= KIND_PEAK;
            value_ff <= head_data.value;
            row_ff <= head_data.row;
            col_ff <= head_data.col;
            total_ff <= '0;
            tallest_out_ff <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = kind_ff;
   assign rsp_peak_value = value_ff;
   assign rsp_peak_row = row_ff;
   assign rsp_peak_col = col_ff;
   assign rsp_peak_total = total_ff;
   assign rsp_tallest = tallest_out_ff;

endmodule

>>> tb/sv/grid_local_peak_detector_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid local peak detector checker
// Follows the register port and both channels, keeps its own copy of the
// raster state, predicts every result and compares it field by field.
// ---------------------------------------------------------------------------
module grid_local_peak_detector_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic signed [15:0]              req_elevation,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_kind,
   input  logic signed [15:0]              rsp_peak_value,
   input  logic [5:0]                      rsp_peak_row,
   input  logic [5:0]                      rsp_peak_col,
   input  logic [11:0]                     rsp_peak_total,
   input  logic [14:0]                     rsp_tallest,
   input  logic                            csr_wr_en,
   input  logic [glp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [glp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              fail_count,
   output int                              outstanding,
   output int                              peaks_seen,
   output int                              summaries_seen
);
   import glp_pkg::*;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] value;
      logic [5:0]         row;
      logic [5:0]         col;
      logic [11:0]        total;
      logic [14:0]        tallest;
   } grid_report_type;

   grid_report_type    expected_reports[$];

   logic signed [15:0] store_a [GRID_MAX_COLS];
   logic signed [15:0] store_b [GRID_MAX_COLS];
   logic               fill_b;          // the current row goes to store_b
   int                 col_pos;
   int                 row_pos;
   logic [11:0]        frame_peaks;
   logic signed [15:0] frame_tallest;
   logic [6:0]         cols_reg;
   logic [6:0]         rows_reg;
   int                 print_budget;

   function automatic int clamp_dim(input logic [6:0] raw, input int hi);
      if (raw < GRID_MIN_DIM) return int'(GRID_MIN_DIM);
      if (int'(raw) > hi) return hi;
      return int'(raw);
   endfunction

   task automatic clear_frame();
      fill_b = 1'b0;
      col_pos = 0;
      row_pos = 0;
      frame_peaks = '0;
      frame_tallest = '0;
   endtask

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (print_budget > 0) begin
         $display("[%0t] checker: %s", $time, msg);
         print_budget--;
      end
   endtask

   // One accepted sample: test the cell above it, store it, move on.
   task automatic advance_raster(input logic signed [15:0] sample);
      int                 cols;
      int                 rows;
      int                 c;
      int                 r;
      bit                 end_row;
      bit                 end_frame;
      bit                 found;
      logic signed [15:0] mid;
      logic signed [15:0] west;
      logic signed [15:0] east;
      logic signed [15:0] north;
      grid_report_type    rep;
      cols = clamp_dim(cols_reg, GRID_MAX_COLS);
      rows = clamp_dim(rows_reg, int'(GRID_ROWS_LIMIT));
      c = col_pos;
      r = row_pos;
      end_row = (c >= cols - 1);
      end_frame = end_row && (r >= rows - 1);
      found = 1'b0;
      if (r >= 2 && c >= 1 && c + 1 < cols) begin
         mid   = fill_b ? store_a[c]     : store_b[c];
         west  = fill_b ? store_a[c - 1] : store_b[c - 1];
         east  = fill_b ? store_a[c + 1] : store_b[c + 1];
         north = fill_b ? store_b[c]     : store_a[c];
         if (mid > west && mid > east && mid > north && mid > sample) begin
            if (frame_peaks != PEAK_COUNT_MAX) frame_peaks++;
            if (mid > frame_tallest) frame_tallest = mid;
            rep = '0;
            rep.kind = KIND_PEAK;
            rep.value = mid;
            rep.row = 6'(r - 1);
            rep.col = 6'(c);
            found = 1'b1;
         end
      end
      if (fill_b) store_b[c] = sample;
      else store_a[c] = sample;
      if (end_frame) begin
         rep = '0;
         rep.kind = KIND_SUMMARY;
         rep.total = frame_peaks;
         rep.tallest = frame_tallest[14:0];
         expected_reports = {expected_reports, rep};
         clear_frame();
      end else begin
         if (found) expected_reports = {expected_reports, rep};
         if (end_row) begin
            col_pos = 0;
            row_pos = r + 1;
            fill_b = ~fill_b;
         end else begin
            col_pos = c + 1;
         end
      end
   endtask

   task automatic check_report();
      grid_report_type got;
      grid_report_type want;
      string           diffs;
      got = {rsp_kind, rsp_peak_value, rsp_peak_row, rsp_peak_col,
             rsp_peak_total, rsp_tallest};
      if (expected_reports.size() == 0) begin
         report_mismatch($sformatf("result with nothing pending: kind %0d value %0d",
                                   got.kind, got.value));
         return;
      end
      want = expected_reports.pop_front();
      diffs = "";
      if (got.kind !== want.kind)
         diffs = {diffs, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
      if (got.value !== want.value)
         diffs = {diffs, $sformatf(" value %0d/%0d", got.value, want.value)};
      if (got.row !== want.row)
         diffs = {diffs, $sformatf(" row %0d/%0d", got.row, want.row)};
      if (got.col !== want.col)
         diffs = {diffs, $sformatf(" col %0d/%0d", got.col, want.col)};
      if (got.total !== want.total)
         diffs = {diffs, $sformatf(" total %0d/%0d", got.total, want.total)};
      if (got.tallest !== want.tallest)
         diffs = {diffs, $sformatf(" tallest %0d/%0d", got.tallest, want.tallest)};
      if (diffs != "")
         report_mismatch($sformatf("kind %0d result wrong (got/expected):%s",
                                   want.kind, diffs));
      if (want.kind == KIND_SUMMARY) summaries_seen++;
      else peaks_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_reports.delete();
         clear_frame();
         cols_reg = GRID_COLS_RESET;
         rows_reg = GRID_ROWS_RESET;
         fail_count = 0;
         peaks_seen = 0;
         summaries_seen = 0;
         print_budget = 150;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_GRID_COLS: cols_reg = csr_wdata;
               CSR_GRID_ROWS: rows_reg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) check_report();
         if (req_valid && !req_stall) advance_raster(req_elevation);
      end
      outstanding <= expected_reports.size();
   end

endmodule

>>> tb/sv/grid_local_peak_detector_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid local peak detector testbench
// Streams raster frames of Q12.4 samples through the detector under random
// idling on both channels and lets the checker predict and compare results.
// ---------------------------------------------------------------------------
// The run opens with directed frames: the reset geometry, both dimensions at
// their extremes and past them, tie and sign cases on 3 by 3 grids, and a
// geometry change in the middle of a frame. Random frames follow, most of
// them small, with varied terrain, occasional mid-frame reprogramming, a
// calm stretch with no idling and long receiver hold-offs.
// ---------------------------------------------------------------------------
module grid_local_peak_detector_tb;
   import glp_pkg::*;

   localparam int IDLE_PERCENT  = 26;
   localparam int HOLD_CYCLES   = 60;
   localparam int DRAIN_CYCLES  = 12;
   localparam int DRAIN_GUARD   = 5000;
   localparam int RANDOM_ITEMS  = 1300;

   // Kinds of terrain that the random frames are drawn from.
   typedef enum int {
      TERRAIN_TIES,      // a narrow value range, so equal neighbors are common
      TERRAIN_NOISE,     // the full 16-bit range
      TERRAIN_RIDGES,    // a checkerboard of high and low samples, many peaks
      TERRAIN_EXTREMES,  // the most negative and most positive codes, -1, 0, 1 or a random code
      TERRAIN_SUNKEN     // negative only, so the tallest stays at zero
   } terrain_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [15:0]       req_elevation = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_kind;
   logic signed [15:0]       rsp_peak_value;
   logic [5:0]               rsp_peak_row;
   logic [5:0]               rsp_peak_col;
   logic [11:0]              rsp_peak_total;
   logic [14:0]              rsp_tallest;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   int fail_count;
   int outstanding;
   int peaks_seen;
   int summaries_seen;

   // Shared between the stimulus and the receiver process.
   bit calm = 1'b0;       // no idling on either side while set
   bit hold_req = 1'b0;   // asks the receiver for one long hold-off

   int items_sent = 0;
   int reg_writes = 0;
   int holds_done = 0;
   int grid_cols_eff = 7;
   int grid_rows_eff = 7;

   grid_local_peak_detector u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_elevation  (req_elevation),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_peak_value (rsp_peak_value),
      .rsp_peak_row   (rsp_peak_row),
      .rsp_peak_col   (rsp_peak_col),
      .rsp_peak_total (rsp_peak_total),
      .rsp_tallest    (rsp_tallest),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   grid_local_peak_detector_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_elevation  (req_elevation),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_peak_value (rsp_peak_value),
      .rsp_peak_row   (rsp_peak_row),
      .rsp_peak_col   (rsp_peak_col),
      .rsp_peak_total (rsp_peak_total),
      .rsp_tallest    (rsp_tallest),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .peaks_seen     (peaks_seen),
      .summaries_seen (summaries_seen)
   );

   always #1 clock = ~clock;

   // The block uses out-of-range register values clamped into 3..64; the
   // stimulus needs the same sizes to know how many samples make a frame.
   function automatic int usable_dim(input logic [6:0] raw);
      if (raw < GRID_MIN_DIM) return int'(GRID_MIN_DIM);
      if (raw > GRID_ROWS_LIMIT) return int'(GRID_ROWS_LIMIT);
      return int'(raw);
   endfunction

   function automatic logic signed [15:0] make_sample(input terrain_type style,
                                                      input int r, input int c);
      int t;
      case (style)
         TERRAIN_TIES: t = $urandom_range(0, 6) - 3;
         TERRAIN_NOISE: t = $urandom;
         TERRAIN_RIDGES: begin
            if ((r + c) % 2 == 0) t = $urandom_range(16384, 32767);
            else t = int'($urandom_range(0, 32767)) - 32768;
         end
         TERRAIN_EXTREMES: begin
            case ($urandom_range(0, 5))
               0: t = -32768;
               1: t = 32767;
               2: t = -1;
               3: t = 0;
               4: t = 1;
               default: t = $urandom;
            endcase
         end
         default: t = -1 - int'($urandom_range(0, 32767));
      endcase
      return t[15:0];
   endfunction

   // Offers one sample and returns right after the edge that accepted it.
   // Random idle cycles come before the offer, never while it is pending,
   // so a stalled item keeps its payload.
   task automatic offer_sample(input logic signed [15:0] sample);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_elevation <= sample;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Sends a run of samples; row and column only shape the terrain, the
   // block keeps its own raster position.
   task automatic send_samples(input int count, input terrain_type style);
      for (int i = 0; i < count; i++)
         offer_sample(make_sample(style, i / grid_cols_eff, i % grid_cols_eff));
   endtask

   // A 3 by 3 frame whose only candidate is the center.
   task automatic send_cross(input logic signed [15:0] center,
                             input logic signed [15:0] up,
                             input logic signed [15:0] left,
                             input logic signed [15:0] right,
                             input logic signed [15:0] down,
                             input logic signed [15:0] rest);
      for (int i = 0; i < 9; i++) begin
         case (i)
            1: offer_sample(up);
            3: offer_sample(left);
            4: offer_sample(center);
            5: offer_sample(right);
            7: offer_sample(down);
            default: offer_sample(rest);
         endcase
      end
   endtask

   // Drops valid and waits until every pending result has come back, then
   // waits on for samples that produce nothing but are still in the
   // pipeline. Registers are only written after this.
   task automatic settle();
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      @(posedge clock);
      while (outstanding != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      reg_writes++;
   endtask

   task automatic set_grid(input logic [6:0] cols_raw, input logic [6:0] rows_raw);
      settle();
      write_reg(CSR_GRID_COLS, cols_raw);
      write_reg(CSR_GRID_ROWS, rows_raw);
      grid_cols_eff = usable_dim(cols_raw);
      grid_rows_eff = usable_dim(rows_raw);
   endtask

   // Picks a new geometry: mostly small grids, now and then one long
   // dimension, and sometimes raw register values that need clamping. Both
   // dimensions large at once would make one frame longer than the run.
   task automatic choose_grid();
      logic [6:0] raw_c;
      logic [6:0] raw_r;
      int         pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         raw_c = 7'($urandom);
         raw_r = 7'($urandom);
         if (usable_dim(raw_c) * usable_dim(raw_r) > 600) raw_r = 7'($urandom_range(0, 5));
      end else if (pick == 1) begin
         raw_c = 7'($urandom_range(40, 64));
         raw_r = 7'($urandom_range(3, 5));
      end else if (pick == 2) begin
         raw_c = 7'($urandom_range(3, 5));
         raw_r = 7'($urandom_range(40, 64));
      end else begin
         raw_c = 7'($urandom_range(3, 10));
         raw_r = 7'($urandom_range(3, 8));
      end
      set_grid(raw_c, raw_r);
   endtask

   // Receiver: random stalls, none during the calm stretch, and on request
   // one long hold-off counted here so the sender keeps pushing meanwhile.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clock);
            holds_done++;
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   initial begin
      #2_000_000;
      $display("timeout: items or results stopped moving");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int          directed_items;
      int          frame_no;
      int          prefix;
      terrain_type style;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The reset geometry is 7 by 7; run one frame on it untouched.
      send_samples(grid_cols_eff * grid_rows_eff, TERRAIN_RIDGES);

      // Widest grid, with both values past their legal range. This frame also
      // writes every entry of both line stores, so later geometry changes
      // never read an entry that was never written.
      set_grid(7'd127, 7'd0);
      send_samples(grid_cols_eff * grid_rows_eff, TERRAIN_NOISE);

      // Single-candidate frames: the largest code surrounded by the smallest,
      // a tie with the left neighbor, a negative peak that leaves the tallest
      // at zero, a tie with the neighbor below, and the smallest code alone.
      set_grid(7'd3, 7'd3);
      send_cross(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                 16'sh8000);
      send_cross(16'sd100, 16'sd0, 16'sd100, 16'sd0, 16'sd0, 16'sd0);
      send_cross(-16'sd16, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                 16'sh8000);
      send_cross(16'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd5, 16'sd0);
      send_cross(16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);

      // Tallest grid, with the column count below its legal minimum.
      set_grid(7'd2, 7'd64);
      send_samples(grid_cols_eff * grid_rows_eff, TERRAIN_TIES);

      // Shrink the geometry in the middle of a frame so that both raster
      // counters sit on the new last index, then finish the frame.
      set_grid(7'd5, 7'd5);
      send_samples(12, TERRAIN_RIDGES);
      set_grid(7'd3, 7'd3);
      send_samples(9, TERRAIN_RIDGES);
      directed_items = items_sent;

      // Random frames until enough samples have gone through.
      frame_no = 0;
      while (items_sent - directed_items < RANDOM_ITEMS) begin
         frame_no++;
         calm = (frame_no >= 15 && frame_no < 25);
         style = terrain_type'($urandom_range(0, 4));
         if (frame_no == 4 || $urandom_range(0, 24) == 0) begin
            // A peak-rich frame under a long hold-off fills the block's
            // queue, so its input has to stall.
            set_grid(7'd9, 7'd8);
            hold_req = 1'b1;
            send_samples(grid_cols_eff * grid_rows_eff, TERRAIN_RIDGES);
         end else if ($urandom_range(0, 5) == 0) begin
            prefix = $urandom_range(1, grid_cols_eff * grid_rows_eff - 1);
            send_samples(prefix, style);
            choose_grid();
            send_samples(grid_cols_eff * grid_rows_eff, style);
         end else begin
            if ($urandom_range(0, 2) != 0) choose_grid();
            send_samples(grid_cols_eff * grid_rows_eff, style);
         end
      end
      calm = 1'b0;

      settle();
      if (outstanding != 0)
         $display("%0d predicted results never arrived", outstanding);
      $display("Covered %0d samples, %0d frame summaries and %0d reported peaks.",
               items_sent, summaries_seen, peaks_seen);
      $display("Grid registers written %0d times; %0d receiver hold-offs of %0d cycles.",
               reg_writes, holds_done, HOLD_CYCLES);
      if (fail_count == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> grid_local_peak_detector.f
+incdir+sv
sv/glp_pkg.sv
sv/glp_front.sv
sv/glp_queue.sv
sv/glp_back.sv
sv/grid_local_peak_detector.sv
tb/sv/grid_local_peak_detector_checker.sv
tb/sv/grid_local_peak_detector_tb.sv
